@@ rtl/cdde_pkg.sv @@
// Shared types, constants and calendar helper functions for the date/day-count engine.
package cdde_pkg;

  localparam int unsigned ORIGIN_YEAR = 1970;
  localparam int unsigned YEAR_SPAN   = 256;
  localparam int unsigned LAST_YEAR   = ORIGIN_YEAR + YEAR_SPAN - 1;

  localparam logic [2:0] REQ_SET        = 3'd0;
  localparam logic [2:0] REQ_ADD_DAYS   = 3'd1;
  localparam logic [2:0] REQ_ADD_MONTHS = 3'd2;
  localparam logic [2:0] REQ_ADD_YEARS  = 3'd3;

  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_INVALID = 2'd1;
  localparam logic [1:0] ERR_BEFORE  = 2'd2;
  localparam logic [1:0] ERR_PAST    = 2'd3;

  // ceil(2^21 / 12): exact quotient by twelve for magnitudes below 2^19.
  localparam logic [17:0] DIV12_K     = 18'd174763;
  localparam int unsigned DIV12_SHIFT = 21;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SET_CHK,
    ST_ADD_DAYS,
    ST_DIV_MUL,
    ST_DIV_REM,
    ST_YEAR_CHK,
    ST_TO_COUNT,
    ST_FROM_COUNT,
    ST_MONTH_STEP,
    ST_RESP
  } cdde_state_t;

  typedef enum logic [2:0] {
    CV_IDLE,
    CV_TC_YEAR,
    CV_TC_MONTH,
    CV_FC_YEAR,
    CV_FC_MONTH
  } cdde_cv_state_t;

  typedef enum logic {
    CONV_TO_COUNT,
    CONV_FROM_COUNT
  } cdde_cv_mode_t;

  typedef struct packed {
    logic          start;
    cdde_cv_mode_t mode;
    logic [11:0]   year;
    logic [3:0]    month;
    logic [4:0]    day;
    logic [16:0]   count;
  } cdde_cv_req_t;

  typedef struct packed {
    logic        done;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [16:0] count;
  } cdde_cv_rsp_t;

  // Gregorian leap rule; the century test uses a reciprocal of 100 that is
  // exact over all 12-bit years.
  function automatic logic leap_year(input logic [11:0] y);
    logic [22:0] p;
    logic [5:0]  q;
    logic        div100;
    p      = 23'(y) * 23'd1311;
    q      = p[22:17];
    div100 = ((13'(q) * 13'd100) == {1'b0, y});
    return (y[1:0] == 2'b00) && (!div100 || (q[1:0] == 2'b00));
  endfunction

  function automatic logic [8:0] year_len(input logic [11:0] y);
    return leap_year(y) ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
    logic [4:0] len;
    unique case (m)
      4'd2:                     len = lp ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic int unsigned span_days_f();
    int unsigned t;
    t = 0;
    for (int unsigned i = 0; i < YEAR_SPAN; i++) begin
      t = t + int'(year_len(12'(ORIGIN_YEAR + i)));
    end
    return t;
  endfunction

  localparam int unsigned SPAN_DAYS = span_days_f();

  function automatic logic [1:0] count_check(input logic signed [18:0] c);
    logic [1:0] e;
    if (c < 0) begin
      e = ERR_BEFORE;
    end else if (c >= $signed(19'(SPAN_DAYS))) begin
      e = ERR_PAST;
    end else begin
      e = ERR_OK;
    end
    return e;
  endfunction

  function automatic logic [1:0] year_check(input logic signed [19:0] y);
    logic [1:0] e;
    if (y < $signed(20'(ORIGIN_YEAR))) begin
      e = ERR_BEFORE;
    end else if (y > $signed(20'(LAST_YEAR))) begin
      e = ERR_PAST;
    end else begin
      e = ERR_OK;
    end
    return e;
  endfunction

endpackage

@@ rtl/calendar_date_day_count_engine_core.sv @@
// Gregorian date and day-count engine: top level with request sequencer and result register.
//
// Holds one date (year, month, day) and its count of days since 1970-01-01 over the years
// 1970 to 2225, and answers every request beat with exactly one result beat carrying the
// date, the count and an error code; a failing request leaves the held date unchanged.
// One request is worked at a time and s_tready is low until its result is in the output
// register; the next request is taken while that result still waits. The converter walks one
// year or one month per clock cycle from 1970: a read starts no walk, add-days one count-to-date
// walk, set and add-years a date-to-count walk and then a count-to-date walk, and add-months
// adds one more count-to-date walk for each leftover month.
module calendar_date_day_count_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // in_year[11:0], in_month[15:12], in_day[20:16], amount[38:21], zero[39]
  input  logic [39:0] s_tdata,
  // req_type[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_year[11:0], out_month[15:12], out_day[20:16], out_days[37:21], error[39:38]
  output logic [39:0] m_tdata
);

  cdde_pkg::cdde_state_t state, state_next;

  logic [11:0] cur_year;
  logic [3:0]  cur_month;
  logic [4:0]  cur_day;
  logic [16:0] day_count;

  logic [11:0]        ty;
  logic [3:0]         tm;
  logic [4:0]         td;
  logic [16:0]        tc;
  logic signed [17:0] amt;
  logic [34:0]        prod;
  logic signed [18:0] qy;
  logic signed [4:0]  rem;
  logic [1:0]         werr;

  logic [11:0] o_year;
  logic [3:0]  o_month;
  logic [4:0]  o_day;
  logic [16:0] o_days;
  logic [1:0]  o_err;

  logic [11:0]        in_year;
  logic [3:0]         in_month;
  logic [4:0]         in_day;
  logic [17:0]        in_amount;
  logic               accept;
  logic               out_free;
  logic [17:0]        mag;
  logic [13:0]        quo;
  logic [17:0]        rmd_full;
  logic [3:0]         rmd;
  logic signed [19:0] ny;
  logic [1:0]         ny_err;
  logic [4:0]         mlen_cur;
  logic [1:0]         set_err;
  logic signed [18:0] addend;
  logic signed [18:0] sum;
  logic [1:0]         sum_err;

  cdde_pkg::cdde_cv_req_t creq;
  cdde_pkg::cdde_cv_rsp_t crsp;

  cdde_conv u_conv (
    .clk (clk),
    .rst (rst),
    .req (creq),
    .rsp (crsp)
  );

  assign in_year   = s_tdata[11:0];
  assign in_month  = s_tdata[15:12];
  assign in_day    = s_tdata[20:16];
  assign in_amount = s_tdata[38:21];

  assign s_tready = (state == cdde_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Months split into whole years and leftover months, both truncated toward zero.
  assign mag      = amt[17] ? (18'd0 - amt) : amt;
  assign quo      = prod[cdde_pkg::DIV12_SHIFT +: 14];
  assign rmd_full = mag - (18'({quo, 3'b000}) + 18'({quo, 2'b00}));
  assign rmd      = rmd_full[3:0];

  assign ny     = $signed({8'd0, ty}) + $signed({qy[18], qy});
  assign ny_err = cdde_pkg::year_check(ny);

  assign mlen_cur = cdde_pkg::month_len(tm, cdde_pkg::leap_year(ty));
  assign set_err  = ((tm > 4'd12) || (td > mlen_cur)) ? cdde_pkg::ERR_INVALID
                                                      : cdde_pkg::year_check($signed({8'd0, ty}));

  always_comb begin
    if (state == cdde_pkg::ST_ADD_DAYS) begin
      addend = {amt[17], amt};
    end else if (rem[4]) begin
      addend = 19'd0 - {14'd0, mlen_cur};
    end else begin
      addend = {14'd0, mlen_cur};
    end
  end

  assign sum     = $signed({2'b00, tc}) + addend;
  assign sum_err = cdde_pkg::count_check(sum);

  always_comb begin
    state_next = state;
    creq.start = 1'b0;
    creq.mode  = cdde_pkg::CONV_FROM_COUNT;
    creq.year  = ty;
    creq.month = tm;
    creq.day   = td;
    creq.count = sum[16:0];
    unique case (state)
      cdde_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (s_tuser)
            cdde_pkg::REQ_SET:        state_next = cdde_pkg::ST_SET_CHK;
            cdde_pkg::REQ_ADD_DAYS:   state_next = cdde_pkg::ST_ADD_DAYS;
            cdde_pkg::REQ_ADD_MONTHS: state_next = cdde_pkg::ST_DIV_MUL;
            cdde_pkg::REQ_ADD_YEARS:  state_next = cdde_pkg::ST_YEAR_CHK;
            default:                  state_next = cdde_pkg::ST_RESP;
          endcase
        end
      end
      cdde_pkg::ST_SET_CHK: begin
        if (set_err != cdde_pkg::ERR_OK) begin
          state_next = cdde_pkg::ST_RESP;
        end else begin
          creq.start = 1'b1;
          creq.mode  = cdde_pkg::CONV_TO_COUNT;
          state_next = cdde_pkg::ST_TO_COUNT;
        end
      end
      cdde_pkg::ST_ADD_DAYS: begin
        if (sum_err != cdde_pkg::ERR_OK) begin
          state_next = cdde_pkg::ST_RESP;
        end else begin
          creq.start = 1'b1;
          state_next = cdde_pkg::ST_FROM_COUNT;
        end
      end
      cdde_pkg::ST_DIV_MUL: state_next = cdde_pkg::ST_DIV_REM;
      cdde_pkg::ST_DIV_REM: state_next = cdde_pkg::ST_YEAR_CHK;
      cdde_pkg::ST_YEAR_CHK: begin
        if (ny_err != cdde_pkg::ERR_OK) begin
          state_next = cdde_pkg::ST_RESP;
        end else begin
          creq.start = 1'b1;
          creq.mode  = cdde_pkg::CONV_TO_COUNT;
          creq.year  = ny[11:0];
          state_next = cdde_pkg::ST_TO_COUNT;
        end
      end
      cdde_pkg::ST_TO_COUNT: begin
        // The count is rederived into a date so that a day past the month's end rolls over.
        if (crsp.done) begin
          creq.start = 1'b1;
          creq.count = crsp.count;
          state_next = cdde_pkg::ST_FROM_COUNT;
        end
      end
      cdde_pkg::ST_FROM_COUNT: begin
        if (crsp.done) begin
          state_next = cdde_pkg::ST_MONTH_STEP;
        end
      end
      cdde_pkg::ST_MONTH_STEP: begin
        if (rem == 5'sd0) begin
          state_next = cdde_pkg::ST_RESP;
        end else if (sum_err != cdde_pkg::ERR_OK) begin
          state_next = cdde_pkg::ST_RESP;
        end else begin
          creq.start = 1'b1;
          state_next = cdde_pkg::ST_FROM_COUNT;
        end
      end
      cdde_pkg::ST_RESP: begin
        if (out_free) begin
          state_next = cdde_pkg::ST_IDLE;
        end
      end
      default: state_next = cdde_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cdde_pkg::ST_IDLE;
      cur_year  <= 12'(cdde_pkg::ORIGIN_YEAR);
      cur_month <= 4'd1;
      cur_day   <= 5'd1;
      day_count <= 17'd0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == cdde_pkg::ST_MONTH_STEP) && (rem == 5'sd0)) begin
        cur_year  <= ty;
        cur_month <= tm;
        cur_day   <= td;
        day_count <= tc;
      end
      if ((state == cdde_pkg::ST_RESP) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == cdde_pkg::ST_RESP) && out_free) begin
      o_year  <= cur_year;
      o_month <= cur_month;
      o_day   <= cur_day;
      o_days  <= day_count;
      o_err   <= werr;
    end
    unique case (state)
      cdde_pkg::ST_IDLE: begin
        if (accept) begin
          tc   <= day_count;
          amt  <= in_amount;
          qy   <= {in_amount[17], in_amount};
          rem  <= 5'sd0;
          werr <= cdde_pkg::ERR_OK;
          if (s_tuser == cdde_pkg::REQ_SET) begin
            ty <= (in_year == 12'd0) ? 12'(cdde_pkg::ORIGIN_YEAR) : in_year;
            tm <= (in_month == 4'd0) ? 4'd1 : in_month;
            td <= (in_day == 5'd0) ? 5'd1 : in_day;
          end else begin
            ty <= cur_year;
            tm <= cur_month;
            td <= cur_day;
          end
        end
      end
      cdde_pkg::ST_SET_CHK:  werr <= set_err;
      cdde_pkg::ST_ADD_DAYS: begin
        werr <= sum_err;
        tc   <= sum[16:0];
      end
      cdde_pkg::ST_DIV_MUL:  prod <= 35'(mag) * 35'(cdde_pkg::DIV12_K);
      cdde_pkg::ST_DIV_REM: begin
        qy  <= amt[17] ? (19'd0 - {5'd0, quo}) : {5'd0, quo};
        rem <= amt[17] ? (5'd0 - {1'b0, rmd}) : {1'b0, rmd};
      end
      cdde_pkg::ST_YEAR_CHK: werr <= ny_err;
      cdde_pkg::ST_TO_COUNT: begin
        if (crsp.done) begin
          tc <= crsp.count;
        end
      end
      cdde_pkg::ST_FROM_COUNT: begin
        if (crsp.done) begin
          ty <= crsp.year;
          tm <= crsp.month;
          td <= crsp.day;
        end
      end
      cdde_pkg::ST_MONTH_STEP: begin
        if (rem != 5'sd0) begin
          werr <= sum_err;
          tc   <= sum[16:0];
          rem  <= rem[4] ? (rem + 5'sd1) : (rem - 5'sd1);
        end
      end
      default: begin
      end
    endcase
  end

  assign m_tdata = {o_err, o_days, o_day, o_month, o_year};

endmodule

@@ rtl/cdde_conv.sv @@
// Iterative date <-> day-count converter: one year or one month per cycle on a shared adder.
module cdde_conv (
  input  logic                   clk,
  input  logic                   rst,
  input  cdde_pkg::cdde_cv_req_t req,
  output cdde_pkg::cdde_cv_rsp_t rsp
);

  cdde_pkg::cdde_cv_state_t state, state_next;

  logic [11:0] tgt_year;
  logic [3:0]  tgt_month;
  logic [4:0]  tgt_day;
  logic [11:0] yy;
  logic [3:0]  mm;
  logic [16:0] acc;
  logic        done;

  logic        lp;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic [8:0]  operand;
  logic        sub;
  logic [17:0] res;
  logic        month_more;
  logic        acc_load;
  logic        yy_inc;
  logic        mm_inc;
  logic        finish;

  assign lp         = cdde_pkg::leap_year(yy);
  assign ylen       = lp ? 9'd366 : 9'd365;
  assign mlen       = cdde_pkg::month_len(mm, lp);
  assign month_more = (mm < tgt_month);

  always_comb begin
    unique case (state)
      cdde_pkg::CV_TC_YEAR,
      cdde_pkg::CV_FC_YEAR:  operand = ylen;
      cdde_pkg::CV_TC_MONTH: operand = month_more ? 9'(mlen) : (9'(tgt_day) - 9'd1);
      default:               operand = 9'(mlen);
    endcase
  end

  assign sub = (state == cdde_pkg::CV_FC_YEAR) || (state == cdde_pkg::CV_FC_MONTH);
  // In the subtract phases the sign bit doubles as the "count below length" compare.
  assign res = sub ? ({1'b0, acc} - 18'(operand)) : ({1'b0, acc} + 18'(operand));

  always_comb begin
    state_next = state;
    acc_load   = 1'b0;
    yy_inc     = 1'b0;
    mm_inc     = 1'b0;
    finish     = 1'b0;
    unique case (state)
      cdde_pkg::CV_IDLE: begin
        if (req.start) begin
          state_next = (req.mode == cdde_pkg::CONV_TO_COUNT) ? cdde_pkg::CV_TC_YEAR
                                                              : cdde_pkg::CV_FC_YEAR;
        end
      end
      cdde_pkg::CV_TC_YEAR: begin
        if (yy < tgt_year) begin
          acc_load = 1'b1;
          yy_inc   = 1'b1;
        end else begin
          state_next = cdde_pkg::CV_TC_MONTH;
        end
      end
      cdde_pkg::CV_TC_MONTH: begin
        acc_load = 1'b1;
        if (month_more) begin
          mm_inc = 1'b1;
        end else begin
          finish     = 1'b1;
          state_next = cdde_pkg::CV_IDLE;
        end
      end
      cdde_pkg::CV_FC_YEAR: begin
        if (!res[17]) begin
          acc_load = 1'b1;
          yy_inc   = 1'b1;
        end else begin
          state_next = cdde_pkg::CV_FC_MONTH;
        end
      end
      cdde_pkg::CV_FC_MONTH: begin
        if ((mm < 4'd12) && !res[17]) begin
          acc_load = 1'b1;
          mm_inc   = 1'b1;
        end else begin
          finish     = 1'b1;
          state_next = cdde_pkg::CV_IDLE;
        end
      end
      default: state_next = cdde_pkg::CV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdde_pkg::CV_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == cdde_pkg::CV_IDLE) && req.start) begin
      tgt_year  <= req.year;
      tgt_month <= req.month;
      tgt_day   <= req.day;
      yy        <= 12'(cdde_pkg::ORIGIN_YEAR);
      mm        <= 4'd1;
      acc       <= (req.mode == cdde_pkg::CONV_TO_COUNT) ? 17'd0 : req.count;
    end else begin
      if (acc_load) begin
        acc <= res[16:0];
      end
      if (yy_inc) begin
        yy <= yy + 12'd1;
      end
      if (mm_inc) begin
        mm <= mm + 4'd1;
      end
    end
  end

  assign rsp.done  = done;
  assign rsp.year  = yy;
  assign rsp.month = mm;
  assign rsp.day   = acc[4:0] + 5'd1;
  assign rsp.count = acc;

endmodule

@@ rtl/cdde_checker.sv @@
// Port-level checker for the date/day-count engine, bound to the top level.
module cdde_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // A result beat that is not taken stays on the bus unchanged.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result beat dropped or changed while stalled");

  // An accepted request drops s_tready, so no second request enters straight behind it.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted on two consecutive cycles");

  // The held date carried by every result beat is inside the supported calendar range.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[11:0] >= 12'(cdde_pkg::ORIGIN_YEAR)) &&
                  (m_tdata[11:0] <= 12'(cdde_pkg::LAST_YEAR)) &&
                  (m_tdata[15:12] >= 4'd1) && (m_tdata[15:12] <= 4'd12) &&
                  (m_tdata[20:16] != 5'd0) &&
                  (m_tdata[37:21] < 17'(cdde_pkg::SPAN_DAYS))))
    else $error("result date or day count out of range");

endmodule

bind calendar_date_day_count_engine_core cdde_checker u_cdde_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
